// ----- sv/spq_pkg.sv -----
// Shared types and codes for the sorted priority queue.
// Used by spq_ctrl, spq_datapath, the top level and the checker.
package spq_pkg;

  localparam int unsigned DEPTH_DEFAULT = 8;

  localparam int unsigned CMD_W = 2;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned PRI_W = 8;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned OCC_W = 4;

  localparam logic [CMD_W-1:0] CMD_ENQ = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DEQ = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLR = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

  // Decoded operation for one accepted transaction.
  typedef struct packed {
    logic load;
    logic enq;
    logic deq;
    logic clr;
  } spq_cmd_t;

endpackage

// ----- sv/sorted_priority_queue_top.sv -----
// Sorted priority queue: up to DEPTH value/priority entries, highest first.
// Accepts one command per transaction on the request channel (cmd_i with
// item_value_i and item_priority_i) and returns one result per command on the
// result channel (out_valid_o, out_value_o, out_priority_o, status_o and
// occupancy_o, the entry count after the command, modulo 16).
// Both channels use valid and stall; a transaction completes on a rising
// edge with valid high and stall low.
// The result is registered at the edge that accepts the command. Throughput
// is one command per cycle while the result receiver does not stall; every
// cell of the sorted shift line compares against the new priority in
// parallel, so an enqueue or a dequeue updates the whole line at once.
// While the result receiver stalls, the held result stays unchanged and the
// request channel stalls too; when the result drains, a new command is taken
// in the same cycle. Reset empties the queue and the result register; entry
// contents are not cleared, since only entries below the count are read.
module sorted_priority_queue_top #(
  parameter int unsigned DEPTH = spq_pkg::DEPTH_DEFAULT
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              req_valid_i,
  output logic                              req_stall_o,
  input  logic [spq_pkg::CMD_W-1:0]         cmd_i,
  input  logic signed [spq_pkg::VAL_W-1:0]  item_value_i,
  input  logic [spq_pkg::PRI_W-1:0]         item_priority_i,
  output logic                              res_valid_o,
  input  logic                              res_stall_i,
  output logic                              out_valid_o,
  output logic signed [spq_pkg::VAL_W-1:0]  out_value_o,
  output logic [spq_pkg::PRI_W-1:0]         out_priority_o,
  output logic [spq_pkg::STAT_W-1:0]        status_o,
  output logic [spq_pkg::OCC_W-1:0]         occupancy_o
);

  spq_pkg::spq_cmd_t cmd;

  spq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_i),
    .req_stall_o (req_stall_o),
    .cmd_i       (cmd_i),
    .res_valid_o (res_valid_o),
    .res_stall_i (res_stall_i),
    .cmd_o       (cmd)
  );

  spq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .item_value_i    (item_value_i),
    .item_priority_i (item_priority_i),
    .out_valid_o     (out_valid_o),
    .out_value_o     (out_value_o),
    .out_priority_o  (out_priority_o),
    .status_o        (status_o),
    .occupancy_o     (occupancy_o)
  );

endmodule

// ----- sv/spq_ctrl.sv -----
// Controller of the sorted priority queue: handshakes and command decode.
// Depends on spq_pkg.
module spq_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       req_valid_i,
  output logic                       req_stall_o,
  input  logic [spq_pkg::CMD_W-1:0]  cmd_i,
  output logic                       res_valid_o,
  input  logic                       res_stall_i,
  output spq_pkg::spq_cmd_t          cmd_o
);

  localparam logic RES_EMPTY = 1'b0;
  localparam logic RES_HOLD  = 1'b1;

  logic state_q, state_d;
  logic fire;

  // A new transaction is taken whenever the result register is free or drains now.
  assign req_stall_o = (state_q == RES_HOLD) && res_stall_i;
  assign fire        = req_valid_i && !req_stall_o;
  assign res_valid_o = (state_q == RES_HOLD);

  always_comb begin
    cmd_o      = '0;
    cmd_o.load = fire;
    case (cmd_i)
      spq_pkg::CMD_ENQ: cmd_o.enq = fire;
      spq_pkg::CMD_DEQ: cmd_o.deq = fire;
      spq_pkg::CMD_CLR: cmd_o.clr = fire;
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      RES_EMPTY: if (fire) state_d = RES_HOLD;
      RES_HOLD: begin
        if (fire) begin
          state_d = RES_HOLD;
        end else if (!res_stall_i) begin
          state_d = RES_EMPTY;
        end
      end
      default: state_d = RES_EMPTY;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= RES_EMPTY;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- sv/spq_datapath.sv -----
// Datapath of the sorted priority queue: a sorted shift line of entries,
// the entry count and the result register. Depends on spq_pkg.
module spq_datapath #(
  parameter int unsigned DEPTH = spq_pkg::DEPTH_DEFAULT
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  spq_pkg::spq_cmd_t                 cmd_i,
  input  logic signed [spq_pkg::VAL_W-1:0]  item_value_i,
  input  logic [spq_pkg::PRI_W-1:0]         item_priority_i,
  output logic                              out_valid_o,
  output logic signed [spq_pkg::VAL_W-1:0]  out_value_o,
  output logic [spq_pkg::PRI_W-1:0]         out_priority_o,
  output logic [spq_pkg::STAT_W-1:0]        status_o,
  output logic [spq_pkg::OCC_W-1:0]         occupancy_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic signed [spq_pkg::VAL_W-1:0] val_q [DEPTH];
  logic signed [spq_pkg::VAL_W-1:0] val_d [DEPTH];
  logic [spq_pkg::PRI_W-1:0]        pri_q [DEPTH];
  logic [spq_pkg::PRI_W-1:0]        pri_d [DEPTH];
  logic [CW-1:0]                    count_q, count_d;
  logic [DEPTH-1:0]                 le;
  logic                             full, empty;
  logic                             res_vld_d;
  logic signed [spq_pkg::VAL_W-1:0] res_val_d;
  logic [spq_pkg::PRI_W-1:0]        res_pri_d;
  logic [spq_pkg::STAT_W-1:0]       res_stat_d;
  logic [CW+spq_pkg::OCC_W-1:0]     occ_ext;

  assign full  = (count_q == CW'(DEPTH));
  assign empty = (count_q == '0);

  // A cell is "at or below" the new entry when it is unused or strictly lower.
  // Since the line is sorted, these flags form a single run down to the last cell.
  always_comb begin
    for (int k = 0; k < DEPTH; k++) begin
      le[k] = (CW'(k) >= count_q) || (pri_q[k] < item_priority_i);
    end
  end

  always_comb begin
    for (int k = 0; k < DEPTH; k++) begin
      val_d[k] = val_q[k];
      pri_d[k] = pri_q[k];
      if (cmd_i.enq && !full) begin
        if (le[k] && (k == 0 || !le[(k == 0) ? 0 : k-1])) begin
          val_d[k] = item_value_i;
          pri_d[k] = item_priority_i;
        end else if (k > 0 && le[(k == 0) ? 0 : k-1]) begin
          val_d[k] = val_q[(k == 0) ? 0 : k-1];
          pri_d[k] = pri_q[(k == 0) ? 0 : k-1];
        end
      end else if (cmd_i.deq && k < DEPTH-1) begin
        val_d[k] = val_q[(k < DEPTH-1) ? k+1 : k];
        pri_d[k] = pri_q[(k < DEPTH-1) ? k+1 : k];
      end
    end
  end

  always_comb begin
    count_d    = count_q;
    res_vld_d  = 1'b0;
    res_val_d  = '0;
    res_pri_d  = '0;
    res_stat_d = spq_pkg::STAT_OK;
    if (cmd_i.enq) begin
      if (full) begin
        res_stat_d = spq_pkg::STAT_FULL;
      end else begin
        count_d = count_q + CW'(1);
      end
    end else if (cmd_i.deq) begin
      if (empty) begin
        res_stat_d = spq_pkg::STAT_EMPTY;
      end else begin
        res_vld_d = 1'b1;
        res_val_d = val_q[0];
        res_pri_d = pri_q[0];
        count_d   = count_q - CW'(1);
      end
    end else if (cmd_i.clr) begin
      count_d = '0;
    end
  end

  // Occupancy is reported modulo 16.
  assign occ_ext = {{spq_pkg::OCC_W{1'b0}}, count_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.load) begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      val_q          <= val_d;
      pri_q          <= pri_d;
      out_valid_o    <= res_vld_d;
      out_value_o    <= res_val_d;
      out_priority_o <= res_pri_d;
      status_o       <= res_stat_d;
      occupancy_o    <= occ_ext[spq_pkg::OCC_W-1:0];
    end
  end

endmodule

// ----- sv/spq_checker.sv -----
// Port-level checks for the sorted priority queue, bound to the top level.
// Depends on spq_pkg.
module spq_port_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              req_valid_i,
  input logic                              req_stall_o,
  input logic                              res_valid_o,
  input logic                              res_stall_i,
  input logic                              out_valid_o,
  input logic signed [spq_pkg::VAL_W-1:0]  out_value_o,
  input logic [spq_pkg::STAT_W-1:0]        status_o,
  input logic [spq_pkg::OCC_W-1:0]         occupancy_o
);

  // A stalled result transaction must be held.
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_stall_i |=> res_valid_o && $stable(out_value_o)
      && $stable(status_o))
    else $error("result changed while stalled");

  // Every accepted request yields a result in the next cycle.
  a_res_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && !req_stall_o |=> res_valid_o)
    else $error("no result after accepted request");

  // A returned entry always comes with an ok status.
  a_deq_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && out_valid_o |-> status_o == spq_pkg::STAT_OK)
    else $error("returned entry with error status");

  // A dequeue on empty leaves the queue empty and returns no entry.
  a_empty_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && status_o == spq_pkg::STAT_EMPTY |-> !out_valid_o && occupancy_o == '0)
    else $error("empty status with entry or nonzero occupancy");

endmodule

bind sorted_priority_queue_top spq_port_checker u_spq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_valid_i),
  .req_stall_o (req_stall_o),
  .res_valid_o (res_valid_o),
  .res_stall_i (res_stall_i),
  .out_valid_o (out_valid_o),
  .out_value_o (out_value_o),
  .status_o    (status_o),
  .occupancy_o (occupancy_o)
);

// ----- dv/spq_checker.sv -----
`timescale 1ns / 1ps
// Checker for the sorted priority queue: watches both channels, keeps its own
// sorted copy of the queue and compares every result field by field.
// Depends on spq_pkg for widths and codes.
module spq_checker #(
  parameter int unsigned DEPTH = spq_pkg::DEPTH_DEFAULT
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              req_valid_i,
  input  logic                              req_stall_i,
  input  logic [spq_pkg::CMD_W-1:0]         cmd_i,
  input  logic signed [spq_pkg::VAL_W-1:0]  item_value_i,
  input  logic [spq_pkg::PRI_W-1:0]         item_priority_i,
  input  logic                              res_valid_i,
  input  logic                              res_stall_i,
  input  logic                              out_valid_i,
  input  logic signed [spq_pkg::VAL_W-1:0]  out_value_i,
  input  logic [spq_pkg::PRI_W-1:0]         out_priority_i,
  input  logic [spq_pkg::STAT_W-1:0]        status_i,
  input  logic [spq_pkg::OCC_W-1:0]         occupancy_i,
  output int                                errors_o,
  output int                                pending_o,
  output int                                dropped_full_o,
  output int                                empty_reads_o
);
  import spq_pkg::*;

  localparam int MAX_PRINTED = 40;

  typedef struct packed {
    logic                     hit;
    logic signed [VAL_W-1:0]  value;
    logic [PRI_W-1:0]         prio;
    logic [STAT_W-1:0]        status;
    logic [OCC_W-1:0]         occ;
  } queue_result_t;

  logic signed [VAL_W-1:0] model_val [DEPTH];
  logic [PRI_W-1:0]        model_pri [DEPTH];
  int unsigned             model_count;
  queue_result_t           expected_results [$];

  task automatic report_mismatch(input string what, input logic [VAL_W-1:0] got,
                                 input logic [VAL_W-1:0] want);
    if (errors_o < MAX_PRINTED) begin
      $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    end
    errors_o = errors_o + 1;
  endtask

  // Applies one command to the sorted copy and returns the result it should give.
  function automatic queue_result_t apply_command(input logic [CMD_W-1:0] op,
                                                  input logic signed [VAL_W-1:0] val,
                                                  input logic [PRI_W-1:0] prio);
    queue_result_t r;
    int unsigned   slot;
    int unsigned   k;
    r = '0;
    case (op)
      CMD_ENQ: begin
        if (model_count >= DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          // The new entry goes ahead of the first entry of strictly lower priority.
          slot = model_count;
          for (k = model_count; k > 0; k--) begin
            if (model_pri[k-1] < prio) slot = k - 1;
          end
          for (k = model_count; k > slot; k--) begin
            model_val[k] = model_val[k-1];
            model_pri[k] = model_pri[k-1];
          end
          model_val[slot] = val;
          model_pri[slot] = prio;
          model_count++;
        end
      end
      CMD_DEQ: begin
        if (model_count == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          r.hit = 1'b1;
          r.value = model_val[0];
          r.prio = model_pri[0];
          for (k = 1; k < model_count; k++) begin
            model_val[k-1] = model_val[k];
            model_pri[k-1] = model_pri[k];
          end
          model_count--;
        end
      end
      CMD_CLR: begin
        model_count = 0;
      end
      default: begin
      end
    endcase
    r.occ = OCC_W'(model_count);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    queue_result_t want;
    queue_result_t next_result;
    if (!rst_ni) begin
      model_count = 0;
      expected_results.delete();
      errors_o = 0;
      pending_o = 0;
      dropped_full_o = 0;
      empty_reads_o = 0;
    end else begin
      if (res_valid_i && !res_stall_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with no command outstanding", out_value_i, '0);
        end else begin
          want = expected_results.pop_front();
          if (out_valid_i !== want.hit) report_mismatch("out_valid", out_valid_i, want.hit);
          if (out_value_i !== want.value) report_mismatch("out_value", out_value_i, want.value);
          if (out_priority_i !== want.prio) begin
            report_mismatch("out_priority", out_priority_i, want.prio);
          end
          if (status_i !== want.status) report_mismatch("status", status_i, want.status);
          if (occupancy_i !== want.occ) report_mismatch("occupancy", occupancy_i, want.occ);
        end
      end
      if (req_valid_i && !req_stall_i) begin
        next_result = apply_command(cmd_i, item_value_i, item_priority_i);
        if (next_result.status == STAT_FULL) dropped_full_o = dropped_full_o + 1;
        if (next_result.status == STAT_EMPTY) empty_reads_o = empty_reads_o + 1;
        expected_results.push_back(next_result);
      end
      pending_o = expected_results.size();
    end
  end

endmodule

// ----- dv/tb_sorted_priority_queue_top.sv -----
`timescale 1ns / 1ps
// Testbench top for sorted_priority_queue_top: drives commands with random gaps,
// stalls the result side at random and reports the verdict.
// Depends on spq_pkg, the block itself and spq_checker.
module tb_sorted_priority_queue_top;
  import spq_pkg::*;

  localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;  // unused code; queue unchanged, still gets a result
  localparam int RANDOM_ITEMS = 450;
  localparam int PRESSURE_AT = 150;
  localparam int PRESSURE_CYCLES = 60;
  localparam int WATCHDOG_LIMIT = 1000;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     req_valid = 1'b0;
  logic                     req_stall;
  logic [CMD_W-1:0]         cmd = CMD_NOP;
  logic signed [VAL_W-1:0]  item_value = '0;
  logic [PRI_W-1:0]         item_prio = '0;
  logic                     res_valid;
  logic                     res_stall = 1'b0;
  logic                     out_valid;
  logic signed [VAL_W-1:0]  out_value;
  logic [PRI_W-1:0]         out_prio;
  logic [STAT_W-1:0]        status;
  logic [OCC_W-1:0]         occupancy;

  int   errors;
  int   pending;
  int   dropped_full;
  int   empty_reads;
  int   results_seen = 0;
  int   idle_cycles = 0;
  int   n_enq = 0;
  int   n_deq = 0;
  int   n_clr = 0;
  int   n_nop = 0;
  logic burst_mode = 1'b0;
  logic pressure_done = 1'b0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  sorted_priority_queue_top #(.DEPTH(DEPTH_DEFAULT)) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .req_valid_i     (req_valid),
    .req_stall_o     (req_stall),
    .cmd_i           (cmd),
    .item_value_i    (item_value),
    .item_priority_i (item_prio),
    .res_valid_o     (res_valid),
    .res_stall_i     (res_stall),
    .out_valid_o     (out_valid),
    .out_value_o     (out_value),
    .out_priority_o  (out_prio),
    .status_o        (status),
    .occupancy_o     (occupancy)
  );

  spq_checker #(.DEPTH(DEPTH_DEFAULT)) u_spq_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .req_valid_i     (req_valid),
    .req_stall_i     (req_stall),
    .cmd_i           (cmd),
    .item_value_i    (item_value),
    .item_priority_i (item_prio),
    .res_valid_i     (res_valid),
    .res_stall_i     (res_stall),
    .out_valid_i     (out_valid),
    .out_value_i     (out_value),
    .out_priority_i  (out_prio),
    .status_i        (status),
    .occupancy_i     (occupancy),
    .errors_o        (errors),
    .pending_o       (pending),
    .dropped_full_o  (dropped_full),
    .empty_reads_o   (empty_reads)
  );

  // Mostly back-to-back, sometimes a few cycles, rarely a long pause.
  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 8);
    return $urandom_range(10, 30);
  endfunction

  // Small priorities collide often, so ties and arrival order get exercised.
  function automatic logic [PRI_W-1:0] pick_prio();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 4) return PRI_W'($urandom_range(0, 3));
    if (r == 4) return PRI_W'(255 - $urandom_range(0, 1));
    return PRI_W'($urandom);
  endfunction

  task automatic send_cmd(input logic [CMD_W-1:0] op, input logic signed [VAL_W-1:0] val,
                          input logic [PRI_W-1:0] prio);
    int gap;
    gap = burst_mode ? 0 : pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_valid <= 1'b1;
    cmd <= op;
    item_value <= val;
    item_prio <= prio;
    @(posedge clk_i);
    while (req_stall) @(posedge clk_i);
    case (op)
      CMD_ENQ: n_enq++;
      CMD_DEQ: n_deq++;
      CMD_CLR: n_clr++;
      default: n_nop++;
    endcase
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && res_valid && !res_stall) results_seen <= results_seen + 1;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (req_valid && !req_stall) || (res_valid && !res_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no transaction for %0d cycles, %0d results outstanding.",
               idle_cycles, pending);
      $display("[sorted_priority_queue_top] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: random stalls, none during the burst, and one long hold-off
  // that backs the queue up until the request side stalls as well.
  initial begin : result_sink
    int hold;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!pressure_done && results_seen >= PRESSURE_AT) begin
        res_stall <= 1'b1;
        repeat (PRESSURE_CYCLES) @(negedge clk_i);
        pressure_done = 1'b1;
        res_stall <= 1'b0;
      end else if (burst_mode) begin
        res_stall <= 1'b0;
      end else begin
        hold = pick_gap();
        if (hold > 0) begin
          res_stall <= 1'b1;
          repeat (hold) @(negedge clk_i);
        end
        res_stall <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    int unsigned      r;
    int unsigned      mix;
    int unsigned      enq_share;
    logic [CMD_W-1:0] op;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty read, extreme values and priorities, ties, fill to full,
    // a dropped enqueue, drain, clear with contents and the unused code.
    send_cmd(CMD_DEQ, 32'sd0, 8'd0);
    send_cmd(CMD_ENQ, 32'sh7FFF_FFFF, 8'd0);
    send_cmd(CMD_ENQ, 32'sh8000_0000, 8'd255);
    send_cmd(CMD_ENQ, 32'sd0, 8'd128);
    send_cmd(CMD_ENQ, -32'sd1, 8'd128);
    send_cmd(CMD_ENQ, 32'sh5555_5555, 8'd0);
    send_cmd(CMD_ENQ, 32'shAAAA_AAAA, 8'd255);
    send_cmd(CMD_ENQ, 32'sd7, 8'd1);
    send_cmd(CMD_ENQ, 32'sd8, 8'd254);
    send_cmd(CMD_ENQ, 32'sd9, 8'd255);
    send_cmd(CMD_NOP, -32'sd1, 8'd255);
    repeat (8) send_cmd(CMD_DEQ, 32'sd0, 8'd0);
    send_cmd(CMD_DEQ, -32'sd1, 8'd255);
    send_cmd(CMD_ENQ, 32'sd123, 8'd7);
    send_cmd(CMD_ENQ, -32'sd5, 8'd7);
    send_cmd(CMD_CLR, -32'sd1, 8'd255);
    send_cmd(CMD_DEQ, 32'sd0, 8'd0);
    send_cmd(CMD_ENQ, 32'sd42, 8'd3);

    // Random: phases that lean toward filling, mixing or draining the queue.
    mix = 1;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 30 == 0) mix = $urandom_range(0, 2);
      burst_mode = (i >= 300 && i < 360);
      enq_share = (mix == 0) ? 80 : (mix == 1) ? 50 : 25;
      r = $urandom_range(0, 99);
      if (r < enq_share) op = CMD_ENQ;
      else if (r < 95) op = CMD_DEQ;
      else if (r < 97) op = CMD_CLR;
      else op = CMD_NOP;
      send_cmd(op, $urandom, pick_prio());
    end
    burst_mode = 1'b0;

    @(negedge clk_i);
    req_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);

    $display("Commands: %0d enqueue, %0d dequeue, %0d clear, %0d unused code; %0d results.",
             n_enq, n_deq, n_clr, n_nop, results_seen);
    $display("Enqueues dropped when full: %0d, dequeues on empty: %0d, %0d mismatches.",
             dropped_full, empty_reads, errors);
    if (errors == 0) begin
      $display("[sorted_priority_queue_top] OK");
    end else begin
      $display("[sorted_priority_queue_top] ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/spq_pkg.sv
sv/spq_ctrl.sv
sv/spq_datapath.sv
sv/sorted_priority_queue_top.sv
sv/spq_checker.sv
dv/spq_checker.sv
dv/tb_sorted_priority_queue_top.sv
